[rtl/fpcd_pkg.sv]
package fpcd_pkg;

   localparam int BYTE_W         = 8;
   localparam int NUM_LANES      = 4;
   localparam int SQ_W           = 2 * BYTE_W;
   localparam int SQRT_W         = SQ_W + 1;
   localparam int SQRT_STEPS     = SQ_W / 2;
   localparam int SQRT_TOP       = SQ_W - 2;
   localparam int FRAME_PIXELS_W = 22;
   localparam int CHANNELS_W     = 3;
   localparam int CSR_DATA_W     = 22;

   localparam logic [FRAME_PIXELS_W-1:0] FRAME_PIXELS_RESET = 22'd2097152;
   localparam logic [CHANNELS_W-1:0]     CHANNELS_RESET     = 3'd4;
   localparam logic [BYTE_W-1:0]         DIST_MAX           = 8'hFF;

   typedef enum logic [0:0] {
      CSR_FRAME_PIXELS = 1'b0,
      CSR_CHANNELS     = 1'b1
   } csr_index_type;

   // Per-stage control travelling alongside the pixel data
   typedef struct packed {
      logic valid;
      logic emit;
      logic last;
   } tag_type;

   typedef struct packed {
      logic [SQRT_W-1:0] rem;
      logic [SQRT_W-1:0] root;
   } sqrt_type;

   // One digit of the bitwise integer square root
   function automatic sqrt_type sqrt_step(sqrt_type s, logic [SQRT_W-1:0] bit_val);
      sqrt_type          r;
      logic [SQRT_W-1:0] trial;
      trial = s.root + bit_val;
      r     = s;
      if (s.rem >= trial) begin
         r.rem  = s.rem - trial;
         r.root = (s.root >> 1) + bit_val;
      end else begin
         r.root = s.root >> 1;
      end
      return r;
   endfunction

endpackage

[rtl/fpcd_if.sv]
interface fpcd_req_if;
   import fpcd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] chan0;
   logic [BYTE_W-1:0] chan1;
   logic [BYTE_W-1:0] chan2;
   logic [BYTE_W-1:0] chan3;
   modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                   input ready);
   modport sink (input valid, input chan0, input chan1, input chan2, input chan3,
                 output ready);
endinterface

interface fpcd_rsp_if;
   import fpcd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] distance;
   logic              last_in_frame;
   modport source (output valid, output distance, output last_in_frame, input ready);
   modport sink (input valid, input distance, input last_in_frame, output ready);
endinterface

[rtl/fpcd_dist.sv]
module fpcd_dist #(
   parameter int MAX_CHANNELS = 4
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       advance,
   input  logic [MAX_CHANNELS-1:0]                    lane_en,
   input  fpcd_pkg::tag_type                          in_tag,
   input  logic [MAX_CHANNELS-1:0][fpcd_pkg::BYTE_W-1:0] new_pix,
   input  logic [MAX_CHANNELS-1:0][fpcd_pkg::BYTE_W-1:0] old_pix,
   output fpcd_pkg::tag_type                          out_tag,
   output logic [fpcd_pkg::BYTE_W-1:0]                distance
);
   import fpcd_pkg::*;

   localparam int SUM_W = SQ_W + 1 + $clog2(MAX_CHANNELS);

   tag_type                          tag2_ff, tag3_ff, tag4_ff;
   tag_type                          tag2_in, tag3_in, tag4_in;
   logic [MAX_CHANNELS-1:0][SQ_W-1:0] sq_ff, sq_in;
   logic [SQ_W-1:0]                  val_ff, val_in;
   logic                             sat3_ff, sat3_in;
   logic                             sat4_ff, sat4_in;
   sqrt_type                         st_ff, st_in;
   logic [SUM_W-1:0]                 sum;
   sqrt_type                         st_out;

   // Squared differences, lanes beyond the channel count forced to zero
   always_comb begin
      logic [BYTE_W-1:0] diff;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
         diff     = (new_pix[k] >= old_pix[k]) ? new_pix[k] - old_pix[k]
                                               : old_pix[k] - new_pix[k];
         sq_in[k] = lane_en[k] ? SQ_W'(diff * diff) : '0;
      end
      tag2_in = advance ? in_tag : tag2_ff;
      if (!advance) begin
         sq_in = sq_ff;
      end
   end

   always_comb begin
      sum = '0;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
         sum = sum + SUM_W'(sq_ff[k]);
      end
      tag3_in = advance ? tag2_ff : tag3_ff;
      val_in  = advance ? sum[SQ_W-1:0] : val_ff;
      sat3_in = advance ? (sum[SUM_W-1:SQ_W] != '0) : sat3_ff;
   end

   // Upper half of the root digits
   always_comb begin
      sqrt_type st;
      st = '{rem: SQRT_W'(val_ff), root: '0};
      for (int i = 0; i < SQRT_STEPS / 2; i++) begin
         st = sqrt_step(st, SQRT_W'(1) << (SQRT_TOP - 2 * i));
      end
      tag4_in = advance ? tag3_ff : tag4_ff;
      st_in   = advance ? st : st_ff;
      sat4_in = advance ? sat3_ff : sat4_ff;
   end

   // Lower half of the root digits
   always_comb begin
      st_out = st_ff;
      for (int i = SQRT_STEPS / 2; i < SQRT_STEPS; i++) begin
         st_out = sqrt_step(st_out, SQRT_W'(1) << (SQRT_TOP - 2 * i));
      end
   end

   assign distance = sat4_ff ? DIST_MAX : st_out.root[BYTE_W-1:0];
   assign out_tag  = tag4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else begin
         tag2_ff <= tag2_in;
         tag3_ff <= tag3_in;
         tag4_ff <= tag4_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff   <= sq_in;
      val_ff  <= val_in;
      sat3_ff <= sat3_in;
      st_ff   <= st_in;
      sat4_ff <= sat4_in;
   end

endmodule

[rtl/frame_pixel_color_distance.sv]
// Frame difference by Euclidean colour distance.
// req_ch carries one pixel per transfer (chan0..chan3); pixels arrive in raster
// order and frame_pixels of them make one frame. rsp_ch carries one distance per
// pixel from the second frame after reset on; the first frame gives no results.
// last_in_frame marks the result of a frame's final pixel.
// csr_we/csr_index/csr_wdata write frame_pixels (index 0) and channels (index 1);
// write them only while no pixel is in flight.
// Throughput: one pixel per clock unless rsp_ch stalls. The pixel store is read
// and written at the same address in the transfer cycle, so its single access
// per cycle sets the rate; the channel squares, the sum and two halves of the
// square root each take one register stage.
// A result passes the first-stage, square, sum, upper-root and output registers.
// Reset clears the position counter, the first-frame flag and the pipeline and
// restores frame_pixels to 2097152 and channels to 4; the store is not cleared.
// When rsp_ch stalls, the whole pipeline holds and req_ch.ready drops, so no
// pixel is lost; a waiting result does not block a new transfer while the
// output register is being emptied in the same cycle.
module frame_pixel_color_distance #(
   parameter int MAX_PIXELS   = 2097152,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   fpcd_req_if.sink                          req_ch,
   fpcd_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  fpcd_pkg::csr_index_type           csr_index,
   input  logic [fpcd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fpcd_pkg::*;

   localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CW    = (AW + 1 > FRAME_PIXELS_W) ? AW + 1 : FRAME_PIXELS_W;
   localparam int PIX_W = BYTE_W * MAX_CHANNELS;

   logic [FRAME_PIXELS_W-1:0] frame_pixels_ff, frame_pixels_in;
   logic [CHANNELS_W-1:0]     channels_ff, channels_in;
   logic [AW-1:0]             pos_ff, pos_in;
   logic                      have_prev_ff, have_prev_in;
   tag_type                   tag1_ff, tag1_in;
   logic [MAX_CHANNELS-1:0][BYTE_W-1:0] new_ff, old_ff, pix;
   logic [PIX_W-1:0]          store_mem [MAX_PIXELS];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]         rsp_dist_ff, rsp_dist_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      advance;
   logic                      accept;
   logic                      last;
   logic [CW-1:0]             frame_ext;
   logic [CW-1:0]             eff_n;
   logic [CHANNELS_W-1:0]     eff_ch;
   logic [MAX_CHANNELS-1:0]   lane_en;
   logic [NUM_LANES-1:0][BYTE_W-1:0] lanes;
   tag_type                   out_tag;
   logic [BYTE_W-1:0]         distance;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && advance;
   assign req_ch.ready = advance;

   // Clamp the registers to the ranges the hardware supports
   assign frame_ext = CW'(frame_pixels_ff);
   assign eff_n     = (frame_ext == '0) ? CW'(1)
                    : (frame_ext > CW'(MAX_PIXELS)) ? CW'(MAX_PIXELS) : frame_ext;
   assign eff_ch    = (channels_ff == '0) ? CHANNELS_W'(1)
                    : (channels_ff > CHANNELS_W'(MAX_CHANNELS)) ? CHANNELS_W'(MAX_CHANNELS)
                    : channels_ff;
   assign last      = (CW'(pos_ff) + CW'(1)) >= eff_n;

   assign lanes = {req_ch.chan3, req_ch.chan2, req_ch.chan1, req_ch.chan0};

   always_comb begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
         pix[k]     = lanes[k];
         lane_en[k] = CHANNELS_W'(k) < eff_ch;
      end
   end

   always_comb begin
      frame_pixels_in = frame_pixels_ff;
      channels_in     = channels_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_PIXELS: frame_pixels_in = csr_wdata[FRAME_PIXELS_W-1:0];
            CSR_CHANNELS:     channels_in     = csr_wdata[CHANNELS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      have_prev_in = have_prev_ff;
      if (accept) begin
         pos_in = last ? '0 : pos_ff + AW'(1);
         if (last) begin
            have_prev_in = 1'b1;
         end
      end
      tag1_in = tag1_ff;
      if (advance) begin
         tag1_in = '{valid: accept, emit: have_prev_ff, last: last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pixels_ff <= FRAME_PIXELS_RESET;
         channels_ff     <= CHANNELS_RESET;
         pos_ff          <= '0;
         have_prev_ff    <= 1'b0;
         tag1_ff         <= '0;
      end else begin
         frame_pixels_ff <= frame_pixels_in;
         channels_ff     <= channels_in;
         pos_ff          <= pos_in;
         have_prev_ff    <= have_prev_in;
         tag1_ff         <= tag1_in;
      end
   end

   // Read-first store: the old pixel comes out as the new one goes in
   always_ff @(posedge clock) begin
      if (accept) begin
         store_mem[pos_ff] <= pix;
         old_ff            <= store_mem[pos_ff];
         new_ff            <= pix;
      end
   end

   fpcd_dist #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .lane_en  (lane_en),
      .in_tag   (tag1_ff),
      .new_pix  (new_ff),
      .old_pix  (old_ff),
      .out_tag  (out_tag),
      .distance (distance)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = out_tag.valid && out_tag.emit;
         rsp_dist_in  = distance;
         rsp_last_in  = out_tag.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_dist_ff <= rsp_dist_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.distance      = rsp_dist_ff;
   assign rsp_ch.last_in_frame = rsp_last_ff;

   // No result before a whole frame has been stored
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> have_prev_ff)
      else $error("result presented before the first frame completed");

   // A frame's final pixel wraps the position counter
   assert property (@(posedge clock) disable iff (reset) (accept && last) |=> pos_ff == '0)
      else $error("position counter did not wrap after last pixel");

   // A pixel transfer lands in the first stage with its frame-end mark
   assert property (@(posedge clock) disable iff (reset)
                    accept |=> (tag1_ff.valid && tag1_ff.last == $past(last)))
      else $error("first stage lost a transferred pixel");

endmodule
